// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl modules
// each expects clk and arst_n in the scope where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/pcx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_pkg
// types, header offsets and control structs of the pcx run-length decoder
// ----------------------------------------------------------------------------
package pcx_pkg;

	localparam logic [7:0] HEADER_LEN  = 8'd128;
	localparam logic [1:0] RUN_MARK    = 2'b11;
	localparam logic [7:0] PLANES_ONE  = 8'd1;

	// header byte offsets
	localparam logic [7:0] HDR_XMIN_LO = 8'd4;
	localparam logic [7:0] HDR_XMIN_HI = 8'd5;
	localparam logic [7:0] HDR_YMIN_LO = 8'd6;
	localparam logic [7:0] HDR_YMIN_HI = 8'd7;
	localparam logic [7:0] HDR_XMAX_LO = 8'd8;
	localparam logic [7:0] HDR_XMAX_HI = 8'd9;
	localparam logic [7:0] HDR_YMAX_LO = 8'd10;
	localparam logic [7:0] HDR_YMAX_HI = 8'd11;
	localparam logic [7:0] HDR_PLANES  = 8'd65;
	localparam logic [7:0] HDR_BPL_LO  = 8'd66;
	localparam logic [7:0] HDR_BPL_HI  = 8'd67;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_image;
	} pcx_in_t;

	typedef struct packed {
		logic [7:0]  pixel_value;
		logic [15:0] pixel_x;
		logic [15:0] pixel_y;
		logic        last_of_run;
		logic        bad_depth;
	} pcx_out_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} pcx_state_t;

	typedef struct packed {
		logic take;
		logic emit;
		logic skip;
		logic finish;
	} pcx_cmd_t;

	typedef struct packed {
		logic starts_run;
		logic rem_zero;
		logic col_in_width;
		logic out_free;
	} pcx_sts_t;

	// inclusive extent of lo..hi, zero when the bounds are reversed
	function automatic logic [16:0] extent(input logic [15:0] lo, input logic [15:0] hi);
		logic [16:0] res;
		if (hi >= lo) begin
			res = {1'b0, hi} - {1'b0, lo} + 17'd1;
		end else begin
			res = '0;
		end
		return res;
	endfunction

endpackage

// ===== rtl/pcx_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_ctrl
// sequencer: takes one byte, then steps its pixels out while the output is free, one per cycle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcx_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pcx_pkg::pcx_sts_t sts,
	output pcx_pkg::pcx_cmd_t cmd
);

	pcx_pkg::pcx_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcx_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			pcx_pkg::ST_IDLE: begin
				if (in_valid && sts.out_free && sts.starts_run) begin
					state_d = pcx_pkg::ST_RUN;
				end
			end
			pcx_pkg::ST_RUN: begin
				if (sts.rem_zero) begin
					state_d = pcx_pkg::ST_IDLE;
				end
			end
			default: state_d = pcx_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd        = '0;
		case (state_q)
			pcx_pkg::ST_IDLE: begin
				in_ready = sts.out_free;
				cmd.take = in_valid && sts.out_free;
			end
			pcx_pkg::ST_RUN: begin
				if (sts.rem_zero) begin
					cmd.finish = 1'b1;
				end else if (!sts.col_in_width) begin
					// rest of the run falls past the width, just advance the column
					cmd.skip = 1'b1;
				end else begin
					cmd.emit = sts.out_free;
				end
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	`ASSERT_NEXT(a_run_after_take, cmd.take && sts.starts_run, state_q == pcx_pkg::ST_RUN, "run byte did not start emission")
	`ASSERT_ALWAYS(a_no_take_in_run, !(state_q == pcx_pkg::ST_RUN && in_ready), "input ready while emitting")

endmodule

// ===== rtl/pcx_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_dpath
// header capture, run state, column and row counters and the output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcx_dpath (
	input  logic               clk,
	input  logic               arst_n,
	input  pcx_pkg::pcx_in_t   in_data,
	input  pcx_pkg::pcx_cmd_t  cmd,
	output pcx_pkg::pcx_sts_t  sts,
	output logic               out_valid,
	input  logic               out_ready,
	output pcx_pkg::pcx_out_t  out_data
);

	logic [7:0]  pos_q;
	logic [15:0] xmin_q;
	logic [15:0] ymin_q;
	logic [16:0] width_q;
	logic [16:0] height_q;
	logic [15:0] line_q;
	logic [16:0] col_q;
	logic [16:0] row_q;
	logic [5:0]  run_q;
	logic [5:0]  rem_q;
	logic        await_q;
	logic        halted_q;
	logic [7:0]  value_q;
	logic        out_valid_q;
	pcx_pkg::pcx_out_t out_q;

	logic [7:0]  byte_in;
	logic        hdr_done;
	logic        img_active;
	logic        is_run;
	logic [16:0] col_inc;
	logic        last_px;
	logic        bad_planes;

	assign byte_in    = in_data.data_byte;
	assign hdr_done   = pos_q >= pcx_pkg::HEADER_LEN;
	assign img_active = (row_q < height_q) && (line_q != 16'd0);
	assign is_run     = byte_in[7:6] == pcx_pkg::RUN_MARK;
	assign col_inc    = col_q + 17'd1;
	assign last_px    = (rem_q == 6'd1) || (col_inc >= width_q);
	assign bad_planes = cmd.take && !in_data.start_of_image && !halted_q && !hdr_done
		&& (pos_q == pcx_pkg::HDR_PLANES) && (byte_in != pcx_pkg::PLANES_ONE);

	always_comb begin
		sts.starts_run = 1'b0;
		if (!in_data.start_of_image && !halted_q && hdr_done && img_active) begin
			sts.starts_run = await_q || !is_run;
		end
		sts.rem_zero     = rem_q == 6'd0;
		sts.col_in_width = col_q < width_q;
		sts.out_free     = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			xmin_q      <= '0;
			ymin_q      <= '0;
			width_q     <= '0;
			height_q    <= '0;
			line_q      <= '0;
			col_q       <= '0;
			row_q       <= '0;
			run_q       <= '0;
			rem_q       <= '0;
			await_q     <= 1'b0;
			halted_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !cmd.emit && !bad_planes) begin
				out_valid_q <= 1'b0;
			end

			if (cmd.take) begin
				if (in_data.start_of_image) begin
					// new file: this byte is header byte 0, which holds nothing we keep
					pos_q    <= 8'd1;
					xmin_q   <= '0;
					ymin_q   <= '0;
					width_q  <= '0;
					height_q <= '0;
					line_q   <= '0;
					col_q    <= '0;
					row_q    <= '0;
					run_q    <= '0;
					rem_q    <= '0;
					await_q  <= 1'b0;
					halted_q <= 1'b0;
				end else if (halted_q) begin
					pos_q <= pos_q;
				end else if (!hdr_done) begin
					pos_q <= pos_q + 8'd1;
					case (pos_q)
						pcx_pkg::HDR_XMIN_LO: xmin_q <= {8'd0, byte_in};
						pcx_pkg::HDR_XMIN_HI: xmin_q[15:8] <= byte_in;
						pcx_pkg::HDR_YMIN_LO: ymin_q <= {8'd0, byte_in};
						pcx_pkg::HDR_YMIN_HI: ymin_q[15:8] <= byte_in;
						pcx_pkg::HDR_XMAX_LO: width_q <= {9'd0, byte_in};
						pcx_pkg::HDR_XMAX_HI: width_q <= pcx_pkg::extent(xmin_q,
							{byte_in, width_q[7:0]});
						pcx_pkg::HDR_YMAX_LO: height_q <= {9'd0, byte_in};
						pcx_pkg::HDR_YMAX_HI: height_q <= pcx_pkg::extent(ymin_q,
							{byte_in, height_q[7:0]});
						pcx_pkg::HDR_PLANES: begin
							if (byte_in != pcx_pkg::PLANES_ONE) begin
								halted_q          <= 1'b1;
								out_valid_q       <= 1'b1;
								out_q.pixel_value <= '0;
								out_q.pixel_x     <= '0;
								out_q.pixel_y     <= '0;
								out_q.last_of_run <= 1'b1;
								out_q.bad_depth   <= 1'b1;
							end
						end
						pcx_pkg::HDR_BPL_LO: line_q <= {8'd0, byte_in};
						pcx_pkg::HDR_BPL_HI: line_q[15:8] <= byte_in;
						default: ;
					endcase
				end else if (img_active) begin
					if (await_q) begin
						await_q <= 1'b0;
						value_q <= byte_in;
						rem_q   <= run_q;
					end else if (is_run) begin
						run_q   <= byte_in[5:0];
						await_q <= 1'b1;
					end else begin
						value_q <= byte_in;
						rem_q   <= 6'd1;
					end
				end
			end

			if (cmd.emit) begin
				out_valid_q       <= 1'b1;
				out_q.pixel_value <= value_q;
				out_q.pixel_x     <= col_q[15:0];
				out_q.pixel_y     <= row_q[15:0];
				out_q.last_of_run <= last_px;
				out_q.bad_depth   <= 1'b0;
				rem_q             <= rem_q - 6'd1;
				col_q             <= col_inc;
			end

			if (cmd.skip) begin
				col_q <= col_q + {11'd0, rem_q};
				rem_q <= '0;
			end

			// line end is checked once the whole run is through
			if (cmd.finish && ({1'b0, line_q} <= col_q)) begin
				col_q <= '0;
				row_q <= row_q + 17'd1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`ASSERT_ALWAYS(a_bad_only_halted,
		!(out_valid_q && out_q.bad_depth) || (halted_q && out_q.pixel_x == 16'd0),
		"error result without halt")
	`ASSERT_ALWAYS(a_row_bound, row_q <= height_q, "row counter passed image height")

endmodule

// ===== rtl/pcx_rle_image_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_rle_image_decoder
// pcx run-length decoder for 8-bit single-plane images
// ----------------------------------------------------------------------------
// Feed the file one byte per transaction, with start_of_image on its first
// byte. Header bytes, run-count bytes and dropped bytes are taken in the idle
// state and give no result; a bad plane count gives one error transaction and
// the rest of the file is dropped until the next start mark. A literal pixel
// byte or a colour byte is taken, then its pixels are emitted, then a finish
// step checks for line end. Pixels that fall past the width are stepped over
// in a single skip step, and a run count of zero emits nothing. The sequencer
// steps the run one pixel per cycle into the single output register while
// that register is free and closes it with a line-end step. Input is held off
// while a run is being emitted or the output register is full and not being
// taken.

module pcx_rle_image_decoder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pcx_pkg::pcx_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output pcx_pkg::pcx_out_t out_data
);

	pcx_pkg::pcx_cmd_t cmd;
	pcx_pkg::pcx_sts_t sts;

	pcx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pcx_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== tb/pcx_rle_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_rle_checker
// watches both channels of the pcx decoder, predicts its pixels and compares
// ----------------------------------------------------------------------------
// Every accepted input byte is decoded by a local copy of the decoder state
// and the pixels it should produce are queued. Every accepted output
// transaction is compared against the oldest queued pixel. The mismatch count
// and the number of pixels still owed are handed to the testbench top.

module pcx_rle_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  pcx_pkg::pcx_in_t  in_data,
	input  logic              out_valid,
	input  logic              out_ready,
	input  pcx_pkg::pcx_out_t out_data,
	output int                errors,
	output int                pending
);

	pcx_pkg::pcx_out_t expected_pixels[$];
	int          mism_count;

	// decoder state
	logic [7:0]  hdr_count;
	logic [15:0] org_x;
	logic [15:0] org_y;
	logic [16:0] img_w;
	logic [16:0] img_h;
	logic [15:0] line_len;
	logic [16:0] col;
	logic [16:0] row_idx;
	logic [5:0]  run_cnt;
	logic        want_colour;
	logic        dropped;

	function automatic logic [16:0] span(input logic [15:0] lo, input logic [15:0] hi);
		if (hi < lo) begin
			return '0;
		end
		return {1'b0, hi} - {1'b0, lo} + 17'd1;
	endfunction

	task automatic clear_state();
		hdr_count   = '0;
		org_x       = '0;
		org_y       = '0;
		img_w       = '0;
		img_h       = '0;
		line_len    = '0;
		col         = '0;
		row_idx     = '0;
		run_cnt     = '0;
		want_colour = 1'b0;
		dropped     = 1'b0;
	endtask

	task automatic decode_byte(input pcx_pkg::pcx_in_t item);
		logic [7:0] b;
		logic [7:0] pos;
		logic [7:0] value;
		int         count;
		int         i;
		logic       have;
		pcx_pkg::pcx_out_t px;
		b    = item.data_byte;
		have = 1'b0;
		px   = '0;
		if (item.start_of_image) begin
			clear_state();
		end
		if (dropped) begin
			return;
		end
		if (hdr_count < pcx_pkg::HEADER_LEN) begin
			pos       = hdr_count;
			hdr_count = pos + 8'd1;
			if (pos == pcx_pkg::HDR_PLANES && b != pcx_pkg::PLANES_ONE) begin
				dropped        = 1'b1;
				px.last_of_run = 1'b1;
				px.bad_depth   = 1'b1;
				expected_pixels.push_back(px);
				return;
			end
			case (pos)
				pcx_pkg::HDR_XMIN_LO: org_x = {8'h00, b};
				pcx_pkg::HDR_XMIN_HI: org_x[15:8] = b;
				pcx_pkg::HDR_YMIN_LO: org_y = {8'h00, b};
				pcx_pkg::HDR_YMIN_HI: org_y[15:8] = b;
				pcx_pkg::HDR_XMAX_LO: img_w = {9'd0, b};
				pcx_pkg::HDR_XMAX_HI: img_w = span(org_x, {b, img_w[7:0]});
				pcx_pkg::HDR_YMAX_LO: img_h = {9'd0, b};
				pcx_pkg::HDR_YMAX_HI: img_h = span(org_y, {b, img_h[7:0]});
				pcx_pkg::HDR_BPL_LO: line_len = {8'h00, b};
				pcx_pkg::HDR_BPL_HI: line_len[15:8] = b;
				default: ;
			endcase
			return;
		end
		// image finished or no line length: byte dropped
		if (row_idx >= img_h || line_len == 16'd0) begin
			return;
		end
		if (want_colour) begin
			want_colour = 1'b0;
			value       = b;
			count       = run_cnt;
		end else if (b[7:6] == pcx_pkg::RUN_MARK) begin
			run_cnt     = b[5:0];
			want_colour = 1'b1;
			return;
		end else begin
			value = b;
			count = 1;
		end
		// queue each pixel one step late so the final one can carry last_of_run
		for (i = 0; i < count; i++) begin
			if (col < img_w) begin
				if (have) begin
					expected_pixels.push_back(px);
				end
				px.pixel_value = value;
				px.pixel_x     = col[15:0];
				px.pixel_y     = row_idx[15:0];
				px.last_of_run = 1'b0;
				px.bad_depth   = 1'b0;
				have           = 1'b1;
			end
			col = col + 17'd1;
		end
		if (have) begin
			px.last_of_run = 1'b1;
			expected_pixels.push_back(px);
		end
		if (col >= {1'b0, line_len}) begin
			col     = '0;
			row_idx = row_idx + 17'd1;
		end
	endtask

	task automatic note_mismatch(input string what, input pcx_pkg::pcx_out_t want,
		input pcx_pkg::pcx_out_t got);
		mism_count++;
		if (mism_count <= 10) begin
			$display("%0t %s: expected val=%02h x=%0d y=%0d last=%0b bad=%0b, %s",
				$realtime, what, want.pixel_value, want.pixel_x, want.pixel_y,
				want.last_of_run, want.bad_depth,
				$sformatf("got val=%02h x=%0d y=%0d last=%0b bad=%0b",
				got.pixel_value, got.pixel_x, got.pixel_y, got.last_of_run,
				got.bad_depth));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pcx_pkg::pcx_out_t want;
		if (!arst_n) begin
			clear_state();
			expected_pixels.delete();
			mism_count = 0;
			errors  <= 0;
			pending <= 0;
		end else begin
			if (in_valid && in_ready) begin
				decode_byte(in_data);
			end
			if (out_valid && out_ready) begin
				if (expected_pixels.size() == 0) begin
					note_mismatch("unexpected pixel transaction", '0, out_data);
				end else begin
					want = expected_pixels.pop_front();
					if (out_data.pixel_value !== want.pixel_value
						|| out_data.pixel_x !== want.pixel_x
						|| out_data.pixel_y !== want.pixel_y
						|| out_data.last_of_run !== want.last_of_run
						|| out_data.bad_depth !== want.bad_depth) begin
						note_mismatch("pixel mismatch", want, out_data);
					end
				end
			end
			errors  <= mism_count;
			pending <= expected_pixels.size();
		end
	end

endmodule

// ===== tb/pcx_rle_image_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_rle_image_decoder_tb
// byte-stream stimulus for the pcx run-length decoder
// ----------------------------------------------------------------------------
// Sends whole pcx files: a 128-byte header followed by literal and run-coded
// pixel bytes. A directed set of small files hits the header corner cases
// (missing start mark, reversed bounds, bad plane count, zero line length,
// zero height, full-range width, restarts mid-file), then random files with
// random idle gaps on both sides and one long output hold-off. Checking is
// done by pcx_rle_checker.

module pcx_rle_image_decoder_tb;

	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 200;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	pcx_pkg::pcx_in_t  in_data;
	logic              out_valid;
	logic              out_ready;
	pcx_pkg::pcx_out_t out_data;
	int                errors;
	int                pending;

	logic     tx_idle;
	logic     rx_idle;
	logic     hold_req;
	int       data_items;

	pcx_rle_image_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	pcx_rle_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Mismatches found");
		$finish;
	end

	// mostly no gap, some short ones, a few long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	// output side: random stalls, plus one long hold-off on request
	initial begin
		int gap;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_ready <= 1'b1;
			end else if (rx_idle) begin
				gap = idle_len();
				if (gap > 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// one transaction; valid stays up into the next byte when no gap follows
	task automatic push_byte(input logic [7:0] b, input logic sof);
		pcx_pkg::pcx_in_t item;
		int      gap;
		item.data_byte      = b;
		item.start_of_image = sof;
		in_data  <= item;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		gap = tx_idle ? idle_len() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_header(input logic sof, input logic [15:0] x0, input logic [15:0] y0,
		input logic [15:0] x1, input logic [15:0] y1, input logic [7:0] planes,
		input logic [15:0] bpl, input int upto);
		logic [7:0] b;
		int         i;
		for (i = 0; i < upto; i++) begin
			case (i)
				pcx_pkg::HDR_XMIN_LO: b = x0[7:0];
				pcx_pkg::HDR_XMIN_HI: b = x0[15:8];
				pcx_pkg::HDR_YMIN_LO: b = y0[7:0];
				pcx_pkg::HDR_YMIN_HI: b = y0[15:8];
				pcx_pkg::HDR_XMAX_LO: b = x1[7:0];
				pcx_pkg::HDR_XMAX_HI: b = x1[15:8];
				pcx_pkg::HDR_YMAX_LO: b = y1[7:0];
				pcx_pkg::HDR_YMAX_HI: b = y1[15:8];
				pcx_pkg::HDR_PLANES:  b = planes;
				pcx_pkg::HDR_BPL_LO:  b = bpl[7:0];
				pcx_pkg::HDR_BPL_HI:  b = bpl[15:8];
				default:              b = $urandom_range(0, 255);
			endcase
			push_byte(b, sof && i == 0);
		end
	endtask

	task automatic send_literal(input logic [7:0] b);
		push_byte(b, 1'b0);
		data_items++;
	endtask

	task automatic send_run(input logic [5:0] count, input logic [7:0] colour);
		push_byte({pcx_pkg::RUN_MARK, count}, 1'b0);
		push_byte(colour, 1'b0);
		data_items += 2;
	endtask

	initial begin
		logic [15:0] x0;
		logic [15:0] y0;
		logic [15:0] w;
		logic [15:0] h;
		logic [15:0] bpl;
		logic [7:0]  planes;
		int          n_bytes;
		int          img;
		int          k;
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		in_data    <= '0;
		tx_idle     = 1'b0;
		rx_idle     = 1'b0;
		hold_req    = 1'b0;
		data_items  = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first file without a start mark: 4x2, overshooting run, zero run, long run
		send_header(1'b0, 16'd0, 16'd0, 16'd3, 16'd1, pcx_pkg::PLANES_ONE, 16'd4, 128);
		send_literal(8'h00);
		send_literal(8'hbf);
		send_run(6'd3, 8'hff);
		send_run(6'd0, 8'h55);
		send_run(6'h3f, 8'h80);
		send_literal(8'h12);

		// reversed x bounds: zero width, lines walked silently
		send_header(1'b1, 16'h0105, 16'd0, 16'h0003, 16'd1, pcx_pkg::PLANES_ONE, 16'd2, 128);
		send_literal(8'h01);
		send_literal(8'h7f);
		send_run(6'd2, 8'h33);

		// bad plane count, rest of file dropped
		send_header(1'b1, 16'd0, 16'd0, 16'd1, 16'd0, 8'd3, 16'd2, 128);
		send_literal(8'h44);

		// zero bytes-per-line
		send_header(1'b1, 16'd0, 16'd0, 16'd1, 16'd0, pcx_pkg::PLANES_ONE, 16'd0, 128);
		send_literal(8'h20);
		send_run(6'd1, 8'h21);

		// reversed y bounds: zero height
		send_header(1'b1, 16'd0, 16'd5, 16'd1, 16'd4, pcx_pkg::PLANES_ONE, 16'd2, 128);
		send_literal(8'h30);

		// full 16-bit width, single row at the top of the y range
		send_header(1'b1, 16'd0, 16'hffff, 16'hffff, 16'hffff, pcx_pkg::PLANES_ONE,
			16'd3, 128);
		send_run(6'd5, 8'hc5);
		send_literal(8'h3c);

		// restart while a colour byte is awaited, then mid-header
		send_header(1'b1, 16'd0, 16'd0, 16'd3, 16'd1, pcx_pkg::PLANES_ONE, 16'd4, 128);
		push_byte({pcx_pkg::RUN_MARK, 6'd4}, 1'b0);
		send_header(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, pcx_pkg::PLANES_ONE, 16'd1, 40);
		send_header(1'b1, 16'hfffe, 16'hfffe, 16'hffff, 16'hffff, pcx_pkg::PLANES_ONE,
			16'd2, 128);
		send_literal(8'h0f);
		send_run(6'd2, 8'hf0);
		send_literal(8'h99);

		img = 0;
		data_items = 0;
		while (data_items < 110) begin
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			x0 = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
			y0 = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
			w  = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(30, 70))
				: 16'($urandom_range(0, 6));
			h  = 16'($urandom_range(0, 4));
			bpl = ($urandom_range(0, 11) == 0) ? 16'd0 : w + 16'($urandom_range(0, 2));
			planes = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(2, 255))
				: pcx_pkg::PLANES_ONE;
			if ($urandom_range(0, 19) == 0) begin
				planes = 8'd0;
			end
			if (img == 0) begin
				// dense file for the long output hold-off
				w = 16'd40; h = 16'd3; bpl = 16'd40; planes = pcx_pkg::PLANES_ONE;
				x0 = 16'd0; y0 = 16'd0;
			end
			send_header(1'b1, x0, y0, x0 + w - 16'd1, y0 + h - 16'd1, planes, bpl, 128);
			if (img == 0) begin
				// hold the output just as the pixel bytes start
				hold_req = 1'b1;
			end
			n_bytes = $urandom_range(8, 20);
			for (k = 0; k < n_bytes; k++) begin
				if ($urandom_range(0, 29) == 0) begin
					// cut off mid-file, maybe after a run count
					if ($urandom_range(0, 1) == 0) begin
						push_byte({pcx_pkg::RUN_MARK, 6'($urandom)}, 1'b0);
					end
					break;
				end
				if ($urandom_range(0, 9) < 6) begin
					send_run(($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
						: 6'($urandom_range(0, 6)), 8'($urandom));
				end else begin
					send_literal(8'($urandom_range(0, 8'hbf)));
				end
			end
			img++;
		end

		in_valid <= 1'b0;
		rx_idle   = 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
